// ===== rtl/core/dti_pkg.sv =====
// ============================================================================
// Decision tree inference package
// Shared widths, action codes and node table types.
// ============================================================================
package dti_pkg;

    localparam int MAX_NODES    = 1024;
    localparam int MAX_FEATURES = 64;
    localparam int MAX_DEPTH    = 16;

    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int FEAT_AW = $clog2(MAX_FEATURES);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int ACT_W   = 2;

    typedef logic [ACT_W-1:0] t_action;

    localparam t_action ACT_WR_NODE = 2'd0;
    localparam t_action ACT_WR_FEAT = 2'd1;
    localparam t_action ACT_PREDICT = 2'd2;

    localparam logic [NODE_AW-1:0] ROOT_NODE = '0;

    typedef struct packed {
        logic               is_leaf;
        logic [FEAT_AW-1:0] feature;
        logic [VAL_W-1:0]   value;
        logic [NODE_AW-1:0] left;
        logic [NODE_AW-1:0] right;
    } t_node;

    typedef struct packed {
        logic               en;
        logic [NODE_AW-1:0] addr;
        t_node              data;
    } t_node_wr;

endpackage

// ===== rtl/core/dti_node_store.sv =====
// ============================================================================
// Decision tree node table
// Single-port-write, single-port-read node memory with registered read data.
// The read data holds its value while no read is issued.
// ============================================================================
module dti_node_store (
    input  logic                        i_clk,
    input  dti_pkg::t_node_wr           i_wr,
    input  logic                        i_rd_en,
    input  logic [dti_pkg::NODE_AW-1:0] i_rd_addr,
    output dti_pkg::t_node              o_rd_data
);
    import dti_pkg::*;

    t_node r_mem [MAX_NODES];
    t_node r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/decision_tree_inference_top.sv =====
// ============================================================================
// Decision tree inference top level
// Walks a flattened binary decision tree held in a node table memory, using
// a feature vector held in a second memory.
// ----------------------------------------------------------------------------
// The input channel (i_valid / o_ready) takes one item per transfer. A
// write-node item stores one node table entry and a write-feature item stores
// one feature value; each returns nothing. A predict item walks the table
// from entry 0 and returns one result on the output channel (o_valid / i_ready).
// Each tree level takes a node table read, then a feature store read of the
// feature that node names, since the second address comes from the first
// read. A walk ends at a leaf, or with a depth fault at a non-leaf node at
// depth MAX_DEPTH. The block takes no new item while a walk is in progress.
// The result sits in an output register, so writes are taken while it waits.
// If the receiver stalls and a second walk finishes, that walk holds until
// the register is taken. Reset returns the controller to idle and drops
// o_valid; the memories keep their contents and read as undefined until
// written.
// ============================================================================
module decision_tree_inference_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  dti_pkg::t_action                   i_action,
    input  logic [dti_pkg::NODE_AW-1:0]        i_node_index,
    input  logic                               i_node_is_leaf,
    input  logic [dti_pkg::FEAT_AW-1:0]        i_node_feature,
    input  logic signed [dti_pkg::VAL_W-1:0]   i_node_value,
    input  logic [dti_pkg::NODE_AW-1:0]        i_left_child,
    input  logic [dti_pkg::NODE_AW-1:0]        i_right_child,
    input  logic [dti_pkg::FEAT_AW-1:0]        i_feature_slot,
    input  logic signed [dti_pkg::VAL_W-1:0]   i_feature_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [dti_pkg::VAL_W-1:0]   o_prediction,
    output logic                               o_walk_fault,
    output logic [dti_pkg::DEPTH_W-1:0]        o_depth_reached
);
    import dti_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NODE,
        S_FEAT
    } t_state;

    t_state               r_state;
    logic [DEPTH_W-1:0]   r_depth;
    logic                 r_o_valid;
    logic [VAL_W-1:0]     r_prediction;
    logic                 r_walk_fault;
    logic [DEPTH_W-1:0]   r_depth_reached;
    logic [VAL_W-1:0]     r_feat_mem [MAX_FEATURES];
    logic [VAL_W-1:0]     r_feat_q;

    t_node_wr             node_wr;
    logic                 node_rd_en;
    logic [NODE_AW-1:0]   node_rd_addr;
    t_node                node_q;
    logic                 feat_rd_en;
    logic                 accept;
    logic                 out_free;
    logic                 feat_gt;
    logic                 walk_done;
    logic [VAL_W-1:0]     done_pred;
    logic                 done_fault;

    dti_node_store u_node_store (
        .i_clk     (i_clk),
        .i_wr      (node_wr),
        .i_rd_en   (node_rd_en),
        .i_rd_addr (node_rd_addr),
        .o_rd_data (node_q)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign feat_gt  = $signed(r_feat_q) > $signed(node_q.value);

    always_comb begin
        node_wr.en           = accept && (i_action == ACT_WR_NODE);
        node_wr.addr         = i_node_index;
        node_wr.data.is_leaf = i_node_is_leaf;
        node_wr.data.feature = i_node_feature;
        node_wr.data.value   = i_node_value;
        node_wr.data.left    = i_left_child;
        node_wr.data.right   = i_right_child;

        node_rd_en   = 1'b0;
        node_rd_addr = ROOT_NODE;
        feat_rd_en   = 1'b0;
        walk_done    = 1'b0;
        done_pred    = '0;
        done_fault   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_PREDICT)) begin
                    node_rd_en = 1'b1;
                end
            end
            S_NODE: begin
                if (node_q.is_leaf) begin
                    walk_done = 1'b1;
                    done_pred = node_q.value;
                end else if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                    walk_done  = 1'b1;
                    done_fault = 1'b1;
                end else begin
                    feat_rd_en = 1'b1;
                end
            end
            S_FEAT: begin
                node_rd_en   = 1'b1;
                node_rd_addr = feat_gt ? node_q.left : node_q.right;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_action == ACT_WR_FEAT)) begin
            r_feat_mem[i_feature_slot] <= i_feature_value;
        end
        if (feat_rd_en) begin
            r_feat_q <= r_feat_mem[node_q.feature];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_depth   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && !walk_done) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_action == ACT_PREDICT)) begin
                        r_depth <= '0;
                        r_state <= S_NODE;
                    end
                end
                S_NODE: begin
                    if (walk_done) begin
                        if (out_free) begin
                            r_o_valid       <= 1'b1;
                            r_prediction    <= done_pred;
                            r_walk_fault    <= done_fault;
                            r_depth_reached <= r_depth;
                            r_state         <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_FEAT;
                    end
                end
                S_FEAT: begin
                    r_depth <= r_depth + DEPTH_W'(1);
                    r_state <= S_NODE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_prediction    = r_prediction;
    assign o_walk_fault    = r_walk_fault;
    assign o_depth_reached = r_depth_reached;

endmodule

// ===== rtl/core/dti_checker.sv =====
// ============================================================================
// Decision tree inference port checker
// Checks the top level's ports over time and is bound to the top level.
// ============================================================================
module dti_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input dti_pkg::t_action                   i_action,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [dti_pkg::VAL_W-1:0]   o_prediction,
    input logic                               o_walk_fault,
    input logic [dti_pkg::DEPTH_W-1:0]        o_depth_reached
);
    import dti_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_prediction)
            && $stable(o_walk_fault) && $stable(o_depth_reached))
        else $error("Result changed while the receiver stalled.");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_walk_fault |-> o_prediction == '0)
        else $error("A faulted walk returned a nonzero prediction.");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_depth_reached <= DEPTH_W'(MAX_DEPTH))
        else $error("Reported depth exceeds the depth bound.");

    a_predict_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_action == ACT_PREDICT) |=> !o_ready)
        else $error("A new transfer was taken while a walk was starting.");

endmodule

bind decision_tree_inference_top dti_checker u_dti_checker (.*);

// ===== test/decision_tree_inference_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Decision tree inference testbench
// Loads node tables and feature vectors, runs tree walks, and compares every
// walk result with a shadow tree walker kept in a small scoreboard. Both
// channels idle and stall at random. Walks only ever touch entries that were
// written before.
// ============================================================================
module decision_tree_inference_top_tb;

    import dti_pkg::*;

    localparam t_action ACT_UNUSED    = 2'd3;
    localparam int      RANDOM_ITEMS  = 650;
    localparam int      HOLD_AT       = 30;
    localparam int      HOLD_CYCLES   = 300;
    localparam int      PAUSE_AT      = 300;
    localparam int      DRAIN_CYCLES  = 4 * MAX_DEPTH + 8;
    localparam int      WATCHDOG_LIMIT = 2000;

    typedef struct {
        t_action                 action;
        logic [NODE_AW-1:0]      node_index;
        logic                    node_is_leaf;
        logic [FEAT_AW-1:0]      node_feature;
        logic signed [VAL_W-1:0] node_value;
        logic [NODE_AW-1:0]      left_child;
        logic [NODE_AW-1:0]      right_child;
        logic [FEAT_AW-1:0]      feature_slot;
        logic signed [VAL_W-1:0] feature_value;
    } t_dti_item;

    typedef struct {
        logic signed [VAL_W-1:0] prediction;
        logic                    walk_fault;
        logic [DEPTH_W-1:0]      depth_reached;
    } t_walk_result;

    typedef enum int {GAP_NONE, GAP_NODE, GAP_FEATURE} t_gap_kind;

    class t_walk_scoreboard;
        t_node                   node_mem[MAX_NODES];
        bit                      node_set[MAX_NODES];
        logic signed [VAL_W-1:0] feat_mem[MAX_FEATURES];
        bit                      feat_set[MAX_FEATURES];
        t_walk_result            expected_q[$];
        int                      mismatches;

        function new();
            mismatches = 0;
        endfunction

        function t_walk_result walk_tree();
            t_walk_result       res;
            logic [NODE_AW-1:0] cur;
            t_node              nd;
            res.prediction    = '0;
            res.walk_fault    = 1'b1;
            res.depth_reached = '0;
            cur = ROOT_NODE;
            for (int d = 0; d <= MAX_DEPTH; d++) begin
                nd = node_mem[cur];
                res.depth_reached = DEPTH_W'(d);
                if (nd.is_leaf) begin
                    res.prediction = nd.value;
                    res.walk_fault = 1'b0;
                    return res;
                end
                if (d == MAX_DEPTH) begin
                    return res;
                end
                if ($signed(feat_mem[nd.feature]) > $signed(nd.value)) begin
                    cur = nd.left;
                end else begin
                    cur = nd.right;
                end
            end
            return res;
        endfunction

        // Finds the first entry on the current walk path that was never written.
        function t_gap_kind find_gap(output int idx);
            logic [NODE_AW-1:0] cur;
            t_node              nd;
            idx = 0;
            cur = ROOT_NODE;
            for (int d = 0; d <= MAX_DEPTH; d++) begin
                if (!node_set[cur]) begin
                    idx = int'(cur);
                    return GAP_NODE;
                end
                nd = node_mem[cur];
                if (!feat_set[nd.feature]) begin
                    idx = int'(nd.feature);
                    return GAP_FEATURE;
                end
                if (nd.is_leaf || d == MAX_DEPTH) begin
                    return GAP_NONE;
                end
                if ($signed(feat_mem[nd.feature]) > $signed(nd.value)) begin
                    cur = nd.left;
                end else begin
                    cur = nd.right;
                end
            end
            return GAP_NONE;
        endfunction

        function void note_input(t_dti_item it);
            case (it.action)
                ACT_WR_NODE: begin
                    node_mem[it.node_index] = {it.node_is_leaf, it.node_feature,
                        it.node_value, it.left_child, it.right_child};
                    node_set[it.node_index] = 1'b1;
                end
                ACT_WR_FEAT: begin
                    feat_mem[it.feature_slot] = it.feature_value;
                    feat_set[it.feature_slot] = 1'b1;
                end
                ACT_PREDICT: begin
                    expected_q.insert(expected_q.size(), walk_tree());
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(t_walk_result got);
            t_walk_result want;
            if (expected_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("Unexpected result: prediction %h fault %0d depth %0d",
                        got.prediction, got.walk_fault, got.depth_reached);
                end
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.prediction !== want.prediction || got.walk_fault !== want.walk_fault
                    || got.depth_reached !== want.depth_reached) begin
                if (mismatches < 10) begin
                    $display({"Mismatch: expected prediction %h fault %0d depth %0d,",
                        " got %h %0d %0d"},
                        want.prediction, want.walk_fault, want.depth_reached,
                        got.prediction, got.walk_fault, got.depth_reached);
                end
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    t_action                 i_action = ACT_UNUSED;
    logic [NODE_AW-1:0]      i_node_index = '0;
    logic                    i_node_is_leaf = 1'b0;
    logic [FEAT_AW-1:0]      i_node_feature = '0;
    logic signed [VAL_W-1:0] i_node_value = '0;
    logic [NODE_AW-1:0]      i_left_child = '0;
    logic [NODE_AW-1:0]      i_right_child = '0;
    logic [FEAT_AW-1:0]      i_feature_slot = '0;
    logic signed [VAL_W-1:0] i_feature_value = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic signed [VAL_W-1:0] o_prediction;
    logic                    o_walk_fault;
    logic [DEPTH_W-1:0]      o_depth_reached;

    t_walk_scoreboard sb;
    int               sent_count = 0;
    int               stall_cycles = 0;

    decision_tree_inference_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_node_index    (i_node_index),
        .i_node_is_leaf  (i_node_is_leaf),
        .i_node_feature  (i_node_feature),
        .i_node_value    (i_node_value),
        .i_left_child    (i_left_child),
        .i_right_child   (i_right_child),
        .i_feature_slot  (i_feature_slot),
        .i_feature_value (i_feature_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_prediction    (o_prediction),
        .o_walk_fault    (o_walk_fault),
        .o_depth_reached (o_depth_reached)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("decision_tree_inference_top test failed");
            $finish;
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_dti_item junk_item(t_action act);
        t_dti_item it;
        it.action        = act;
        it.node_index    = NODE_AW'($urandom);
        it.node_is_leaf  = 1'($urandom);
        it.node_feature  = FEAT_AW'($urandom);
        it.node_value    = $urandom;
        it.left_child    = NODE_AW'($urandom);
        it.right_child   = NODE_AW'($urandom);
        it.feature_slot  = FEAT_AW'($urandom);
        it.feature_value = $urandom;
        return it;
    endfunction

    task automatic drive_item(input t_dti_item it);
        int gap;
        gap = (((sent_count / 40) % 3) == 2) ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action        <= it.action;
        i_node_index    <= it.node_index;
        i_node_is_leaf  <= it.node_is_leaf;
        i_node_feature  <= it.node_feature;
        i_node_value    <= it.node_value;
        i_left_child    <= it.left_child;
        i_right_child   <= it.right_child;
        i_feature_slot  <= it.feature_slot;
        i_feature_value <= it.feature_value;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(it);
        sent_count++;
    endtask

    task automatic send_node(input int idx, input bit leaf, input int feat,
                             input logic signed [VAL_W-1:0] val, input int lc, input int rc);
        t_dti_item it;
        it = junk_item(ACT_WR_NODE);
        it.node_index   = NODE_AW'(idx);
        it.node_is_leaf = leaf;
        it.node_feature = FEAT_AW'(feat);
        it.node_value   = val;
        it.left_child   = NODE_AW'(lc);
        it.right_child  = NODE_AW'(rc);
        drive_item(it);
    endtask

    task automatic send_feature(input int slot, input logic signed [VAL_W-1:0] val);
        t_dti_item it;
        it = junk_item(ACT_WR_FEAT);
        it.feature_slot  = FEAT_AW'(slot);
        it.feature_value = val;
        drive_item(it);
    endtask

    task automatic send_op(input t_action act);
        drive_item(junk_item(act));
    endtask

    task automatic send_random_node(input int idx, input int leaf_pct);
        int feat;
        int lc;
        int rc;
        feat = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 63);
        lc = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
        rc = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
        send_node(idx, $urandom_range(0, 99) < leaf_pct, feat, pick_value(), lc, rc);
    endtask

    task automatic run_directed();
        send_feature(0, 32'h7FFF_FFFF);
        send_feature(63, 32'h8000_0000);
        send_node(0, 1'b1, 63, 32'h8000_0000, 1023, 1023);
        send_op(ACT_PREDICT);
        send_node(0, 1'b1, 0, 32'h7FFF_FFFF, 0, 0);
        send_op(ACT_PREDICT);
        send_node(1023, 1'b1, 63, 32'h1234_5678, 0, 0);
        send_node(1, 1'b1, 0, 32'hFFFF_FFFF, 1023, 1023);
        send_node(0, 1'b0, 0, 32'h7FFF_FFFE, 1023, 1);
        send_op(ACT_PREDICT);
        // A feature equal to the threshold takes the right child.
        send_node(0, 1'b0, 0, 32'h7FFF_FFFF, 1023, 1);
        send_op(ACT_PREDICT);
        send_node(0, 1'b0, 63, 32'h8000_0000, 1023, 1);
        send_op(ACT_PREDICT);
        send_node(0, 1'b0, 0, 32'h8000_0000, 1023, 1);
        send_op(ACT_PREDICT);
        // A self loop never meets a leaf, so the walk runs into the depth bound.
        send_node(2, 1'b0, 0, 32'h0000_0000, 2, 2);
        send_node(0, 1'b0, 63, 32'h0000_0000, 2, 2);
        send_op(ACT_PREDICT);
        send_op(ACT_UNUSED);
        send_op(ACT_PREDICT);
    endtask

    task automatic run_random();
        int        start;
        int        r;
        int        idx;
        int        leaf_pct;
        bit        paused;
        t_gap_kind kind;
        start  = sent_count;
        paused = 1'b0;
        while (sent_count - start < RANDOM_ITEMS) begin
            case (((sent_count - start) / 60) % 3)
                0: leaf_pct = 30;
                1: leaf_pct = 8;
                default: leaf_pct = 60;
            endcase
            if (!paused && sent_count - start >= PAUSE_AT) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 30) begin
                idx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 1023);
                send_random_node(idx, leaf_pct);
            end else if (r < 55) begin
                send_feature($urandom_range(0, 63), pick_value());
            end else if (r < 93) begin
                kind = sb.find_gap(idx);
                while (kind != GAP_NONE) begin
                    if (kind == GAP_NODE) begin
                        send_random_node(idx, leaf_pct);
                    end else begin
                        send_feature(idx, pick_value());
                    end
                    kind = sb.find_gap(idx);
                end
                send_op(ACT_PREDICT);
            end else begin
                send_op(ACT_UNUSED);
            end
        end
    endtask

    initial begin : result_sink
        t_walk_result got;
        int           gap;
        int           taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end else if (((taken / 15) % 3) == 2) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 8);
            end
            @(negedge i_clk);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.prediction    = o_prediction;
            got.walk_fault    = o_walk_fault;
            got.depth_reached = o_depth_reached;
            sb.check_result(got);
            taken++;
        end
    end

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("decision_tree_inference_top test passed");
        end else begin
            $display("decision_tree_inference_top test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dti_pkg.sv
rtl/core/dti_node_store.sv
rtl/core/decision_tree_inference_top.sv
rtl/core/dti_checker.sv
test/decision_tree_inference_top_tb.sv
